>>> hdl/tkv_pkg.sv
package tkv_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam int TAG_W = 64;
    localparam int VAL_W = 64;
    localparam int CHUNK_W = 8;

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);

    typedef enum logic [1:0] {
        OP_NOOP   = 2'd0,
        OP_PUT    = 2'd1,
        OP_DELETE = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic             tomb;
        logic [TAG_W-1:0] bucket;
        logic [TAG_W-1:0] key;
    } tag_word_t;

    typedef struct packed {
        logic [VAL_W-1:0]   size;
        logic [VAL_W-1:0]   digest;
        logic [CHUNK_W-1:0] chunks;
    } data_word_t;

endpackage

>>> hdl/tkv_ram.sv
module tkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/tombstone_key_value_table.sv
// A word is handled in steps: the used slots of the tag memory are read and compared one by one,
// up to the first live match, then the word is applied, then its result is offered.
// No new word is taken until that result has been offered.
// The scan is bound by the single read port of the tag memory.
// Reset clears the control state and the used slot count; the memories are not cleared,
// since only slots below the used count are ever read.
module tombstone_key_value_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [63:0] bucket_tag,
    input  logic [63:0] key_tag,
    input  logic [63:0] object_size,
    input  logic [63:0] content_digest,
    input  logic [7:0]  chunk_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [63:0] found_size,
    output logic [63:0] found_digest,
    output logic [7:0]  found_chunks
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_APPLY,
        S_RESULT
    } state_t;

    state_t state_reg;

    tkv_pkg::op_t                     op_reg;
    logic [tkv_pkg::TAG_W-1:0]        bucket_reg;
    logic [tkv_pkg::TAG_W-1:0]        key_reg;
    logic [tkv_pkg::VAL_W-1:0]        size_reg;
    logic [tkv_pkg::VAL_W-1:0]        digest_reg;
    logic [tkv_pkg::CHUNK_W-1:0]      chunks_reg;
    logic [tkv_pkg::CNT_W-1:0]        scan_idx_reg;
    logic [tkv_pkg::CNT_W-1:0]        used_reg;
    logic                             hit_reg;
    logic [tkv_pkg::IDX_W-1:0]        hit_idx_reg;
    logic                             tomb_found_reg;
    logic [tkv_pkg::IDX_W-1:0]        tomb_idx_reg;
    tkv_pkg::status_t                 res_status_reg;

    logic                             out_valid_reg;
    tkv_pkg::status_t                 status_reg;
    logic [tkv_pkg::VAL_W-1:0]        found_size_reg;
    logic [tkv_pkg::VAL_W-1:0]        found_digest_reg;
    logic [tkv_pkg::CHUNK_W-1:0]      found_chunks_reg;

    logic                             tag_wr_en;
    logic [tkv_pkg::IDX_W-1:0]        tag_wr_addr;
    tkv_pkg::tag_word_t               tag_wr_word;
    logic                             tag_rd_en;
    tkv_pkg::tag_word_t               tag_rd_word;

    logic                             data_wr_en;
    logic [tkv_pkg::IDX_W-1:0]        data_wr_addr;
    tkv_pkg::data_word_t              data_wr_word;
    logic                             data_rd_en;
    tkv_pkg::data_word_t              data_rd_word;

    logic                             live_match;
    logic                             scan_last;
    logic                             put_write;
    logic [tkv_pkg::IDX_W-1:0]        put_idx;
    logic                             put_append;
    logic                             out_free;

    tkv_ram #(
        .WIDTH ($bits(tkv_pkg::tag_word_t)),
        .DEPTH (tkv_pkg::ENTRIES)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_wr_en),
        .wr_addr (tag_wr_addr),
        .wr_data (tag_wr_word),
        .rd_en   (tag_rd_en),
        .rd_addr (scan_idx_reg[tkv_pkg::IDX_W-1:0]),
        .rd_data (tag_rd_word)
    );

    tkv_ram #(
        .WIDTH ($bits(tkv_pkg::data_word_t)),
        .DEPTH (tkv_pkg::ENTRIES)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (data_wr_en),
        .wr_addr (data_wr_addr),
        .wr_data (data_wr_word),
        .rd_en   (data_rd_en),
        .rd_addr (hit_idx_reg),
        .rd_data (data_rd_word)
    );

    assign live_match = !tag_rd_word.tomb && (tag_rd_word.bucket == bucket_reg)
                        && (tag_rd_word.key == key_reg);
    assign scan_last = ((scan_idx_reg + tkv_pkg::CNT_ONE) == used_reg);
    assign out_free = !out_valid_reg || !out_stall;

    // Pick the put target: live match, then lowest tombstone, then append while the table has room.
    always_comb
    begin
        put_append = 1'b0;
        put_write = 1'b1;
        if (hit_reg)
        begin
            put_idx = hit_idx_reg;
        end
        else if (tomb_found_reg)
        begin
            put_idx = tomb_idx_reg;
        end
        else
        begin
            put_idx = used_reg[tkv_pkg::IDX_W-1:0];
            if (used_reg == tkv_pkg::CNT_FULL)
            begin
                put_write = 1'b0;
            end
            else
            begin
                put_append = 1'b1;
            end
        end
    end

    always_comb
    begin
        tag_rd_en = (state_reg == S_READ);
        tag_wr_en = 1'b0;
        tag_wr_addr = put_idx;
        tag_wr_word = '{tomb: 1'b0, bucket: bucket_reg, key: key_reg};
        data_wr_en = 1'b0;
        data_wr_addr = put_idx;
        data_wr_word = '{size: size_reg, digest: digest_reg, chunks: chunks_reg};
        data_rd_en = 1'b0;
        if (state_reg == S_APPLY)
        begin
            case (op_reg)
                tkv_pkg::OP_PUT:
                begin
                    tag_wr_en = put_write;
                    data_wr_en = put_write;
                end
                tkv_pkg::OP_DELETE:
                begin
                    tag_wr_en = hit_reg;
                    tag_wr_addr = hit_idx_reg;
                    tag_wr_word.tomb = 1'b1;
                end
                tkv_pkg::OP_LOOKUP:
                begin
                    data_rd_en = hit_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg <= '0;
            out_valid_reg <= 1'b0;
            scan_idx_reg <= '0;
            hit_reg <= 1'b0;
            tomb_found_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != S_RESULT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg <= tkv_pkg::op_t'(operation);
                        bucket_reg <= bucket_tag;
                        key_reg <= key_tag;
                        size_reg <= object_size;
                        digest_reg <= content_digest;
                        chunks_reg <= chunk_count;
                        scan_idx_reg <= '0;
                        hit_reg <= 1'b0;
                        tomb_found_reg <= 1'b0;
                        if ((used_reg != '0) && (operation != tkv_pkg::OP_NOOP))
                        begin
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            state_reg <= S_APPLY;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (live_match)
                    begin
                        hit_reg <= 1'b1;
                        hit_idx_reg <= scan_idx_reg[tkv_pkg::IDX_W-1:0];
                        state_reg <= S_APPLY;
                    end
                    else
                    begin
                        if (tag_rd_word.tomb && !tomb_found_reg)
                        begin
                            tomb_found_reg <= 1'b1;
                            tomb_idx_reg <= scan_idx_reg[tkv_pkg::IDX_W-1:0];
                        end
                        if (scan_last)
                        begin
                            state_reg <= S_APPLY;
                        end
                        else
                        begin
                            scan_idx_reg <= scan_idx_reg + tkv_pkg::CNT_ONE;
                            state_reg <= S_READ;
                        end
                    end
                end
                S_APPLY:
                begin
                    res_status_reg <= tkv_pkg::ST_OK;
                    case (op_reg)
                        tkv_pkg::OP_PUT:
                        begin
                            if (!put_write)
                            begin
                                res_status_reg <= tkv_pkg::ST_FULL;
                            end
                            if (put_append)
                            begin
                                used_reg <= used_reg + tkv_pkg::CNT_ONE;
                            end
                        end
                        tkv_pkg::OP_DELETE,
                        tkv_pkg::OP_LOOKUP:
                        begin
                            if (!hit_reg)
                            begin
                                res_status_reg <= tkv_pkg::ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg <= res_status_reg;
                        if ((op_reg == tkv_pkg::OP_LOOKUP) && hit_reg)
                        begin
                            found_size_reg <= data_rd_word.size;
                            found_digest_reg <= data_rd_word.digest;
                            found_chunks_reg <= data_rd_word.chunks;
                        end
                        else
                        begin
                            found_size_reg <= '0;
                            found_digest_reg <= '0;
                            found_chunks_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign found_size = found_size_reg;
    assign found_digest = found_digest_reg;
    assign found_chunks = found_chunks_reg;

`ifndef SYNTHESIS
    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= tkv_pkg::CNT_FULL)
        else $error("used slot count exceeds table depth");

    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_APPLY) |=> (used_reg == $past(used_reg)))
        else $error("used slot count changed outside apply");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (scan_idx_reg < used_reg))
        else $error("scan index beyond used slots");

    a_found_only_on_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != tkv_pkg::ST_OK))
        |-> ((found_size_reg == '0) && (found_digest_reg == '0)
             && (found_chunks_reg == '0)))
        else $error("found fields set on a failed word");

    a_full_needs_full_table: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_APPLY) && (op_reg == tkv_pkg::OP_PUT) && !put_write)
        |-> (!hit_reg && !tomb_found_reg && (used_reg == tkv_pkg::CNT_FULL)))
        else $error("table full reported with room left");
`endif

endmodule

>>> sim/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_OPS     = 900;
    localparam int KEY_POOL       = 96;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int HOLD_CYCLES    = 600;
    localparam int HOLD_AT        = 640;

    typedef struct {
        tkv_pkg::op_t                op;
        logic [tkv_pkg::TAG_W-1:0]   bucket;
        logic [tkv_pkg::TAG_W-1:0]   key;
        logic [tkv_pkg::VAL_W-1:0]   size;
        logic [tkv_pkg::VAL_W-1:0]   digest;
        logic [tkv_pkg::CHUNK_W-1:0] chunks;
    } table_op_t;

    typedef struct {
        tkv_pkg::status_t            st;
        logic [tkv_pkg::VAL_W-1:0]   size;
        logic [tkv_pkg::VAL_W-1:0]   digest;
        logic [tkv_pkg::CHUNK_W-1:0] chunks;
    } table_result_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [1:0]                  operation;
    logic [tkv_pkg::TAG_W-1:0]   bucket_tag;
    logic [tkv_pkg::TAG_W-1:0]   key_tag;
    logic [tkv_pkg::VAL_W-1:0]   object_size;
    logic [tkv_pkg::VAL_W-1:0]   content_digest;
    logic [tkv_pkg::CHUNK_W-1:0] chunk_count;
    logic                        out_valid;
    logic                        out_stall;
    logic [1:0]                  status;
    logic [tkv_pkg::VAL_W-1:0]   found_size;
    logic [tkv_pkg::VAL_W-1:0]   found_digest;
    logic [tkv_pkg::CHUNK_W-1:0] found_chunks;

    table_op_t     pending_ops[$];
    table_result_t expected_results[$];

    logic                        slot_tomb[tkv_pkg::ENTRIES];
    logic [tkv_pkg::TAG_W-1:0]   slot_bucket[tkv_pkg::ENTRIES];
    logic [tkv_pkg::TAG_W-1:0]   slot_key[tkv_pkg::ENTRIES];
    logic [tkv_pkg::VAL_W-1:0]   slot_size[tkv_pkg::ENTRIES];
    logic [tkv_pkg::VAL_W-1:0]   slot_digest[tkv_pkg::ENTRIES];
    logic [tkv_pkg::CHUNK_W-1:0] slot_chunks[tkv_pkg::ENTRIES];
    int                          slots_used = 0;

    logic [tkv_pkg::TAG_W-1:0] key_pool[KEY_POOL];
    logic [tkv_pkg::TAG_W-1:0] bucket_pool[3];

    int total_ops;
    int in_count = 0;
    int error_count = 0;
    int idle_cycles;
    int hold_left;
    bit hold_done;

    tombstone_key_value_table i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .bucket_tag     (bucket_tag),
        .key_tag        (key_tag),
        .object_size    (object_size),
        .content_digest (content_digest),
        .chunk_count    (chunk_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .found_size     (found_size),
        .found_digest   (found_digest),
        .found_chunks   (found_chunks)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int sender_idle_pct(int n);
        if (n < 300)
            return 35;
        else if (n < 600)
            return 62;
        return 0;
    endfunction

    function automatic int receiver_idle_pct(int n);
        if (n < 300)
            return 62;
        else if (n < 600)
            return 35;
        return 0;
    endfunction

    function automatic int find_live_slot(logic [tkv_pkg::TAG_W-1:0] bucket,
                                          logic [tkv_pkg::TAG_W-1:0] key);
        for (int s = 0; s < slots_used; s++)
        begin
            if (!slot_tomb[s] && slot_bucket[s] == bucket && slot_key[s] == key)
                return s;
        end
        return -1;
    endfunction

    task automatic store_slot(int s, table_op_t w);
        slot_bucket[s] = w.bucket;
        slot_key[s]    = w.key;
        slot_size[s]   = w.size;
        slot_digest[s] = w.digest;
        slot_chunks[s] = w.chunks;
        slot_tomb[s]   = 1'b0;
    endtask

    task automatic predict_table_op(input table_op_t w, output table_result_t r);
        int hit;
        int free_slot;
        r.st     = tkv_pkg::ST_OK;
        r.size   = '0;
        r.digest = '0;
        r.chunks = '0;
        hit = find_live_slot(w.bucket, w.key);
        case (w.op)
            tkv_pkg::OP_PUT:
            begin
                if (hit >= 0)
                    store_slot(hit, w);
                else
                begin
                    free_slot = -1;
                    for (int s = 0; s < slots_used; s++)
                    begin
                        if (free_slot < 0 && slot_tomb[s])
                            free_slot = s;
                    end
                    if (free_slot >= 0)
                        store_slot(free_slot, w);
                    else if (slots_used >= tkv_pkg::ENTRIES)
                        r.st = tkv_pkg::ST_FULL;
                    else
                    begin
                        store_slot(slots_used, w);
                        slots_used++;
                    end
                end
            end
            tkv_pkg::OP_DELETE:
            begin
                if (hit < 0)
                    r.st = tkv_pkg::ST_NOT_FOUND;
                else
                    slot_tomb[hit] = 1'b1;
            end
            tkv_pkg::OP_LOOKUP:
            begin
                if (hit < 0)
                    r.st = tkv_pkg::ST_NOT_FOUND;
                else
                begin
                    r.size   = slot_size[hit];
                    r.digest = slot_digest[hit];
                    r.chunks = slot_chunks[hit];
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic add_op(tkv_pkg::op_t op, logic [63:0] bucket, logic [63:0] key,
                          logic [63:0] size, logic [63:0] digest, logic [7:0] chunks);
        table_op_t w;
        w.op     = op;
        w.bucket = bucket;
        w.key    = key;
        w.size   = size;
        w.digest = digest;
        w.chunks = chunks;
        pending_ops.push_back(w);
    endtask

    initial
    begin
        logic [63:0]  ones;
        logic [63:0]  b;
        logic [63:0]  k;
        int           pick;
        int           key_range;
        int           bucket_range;
        tkv_pkg::op_t op;

        ones = '1;
        rst_n = 1'b0;

        bucket_pool[0] = '0;
        bucket_pool[1] = ones;
        bucket_pool[2] = rand64();
        key_pool[0] = '0;
        key_pool[1] = ones;
        for (int i = 2; i < KEY_POOL; i++)
            key_pool[i] = rand64();

        add_op(tkv_pkg::OP_NOOP,   ones, ones, ones, ones, 8'hFF);
        add_op(tkv_pkg::OP_LOOKUP, '0, '0, '0, '0, '0);
        add_op(tkv_pkg::OP_DELETE, '0, '0, '0, '0, '0);
        add_op(tkv_pkg::OP_PUT,    '0, '0, ones, '0, 8'hFF);
        add_op(tkv_pkg::OP_PUT,    ones, ones, '0, ones, '0);
        add_op(tkv_pkg::OP_LOOKUP, '0, '0, '0, '0, '0);
        add_op(tkv_pkg::OP_LOOKUP, ones, ones, '0, '0, '0);
        add_op(tkv_pkg::OP_LOOKUP, '0, ones, '0, '0, '0);
        add_op(tkv_pkg::OP_LOOKUP, ones, '0, '0, '0, '0);
        add_op(tkv_pkg::OP_PUT,    '0, '0, 64'h0123_4567_89AB_CDEF,
               64'hFEDC_BA98_7654_3210, 8'h5A);
        add_op(tkv_pkg::OP_LOOKUP, '0, '0, '0, '0, '0);
        add_op(tkv_pkg::OP_DELETE, '0, '0, '0, '0, '0);
        add_op(tkv_pkg::OP_LOOKUP, '0, '0, '0, '0, '0);
        add_op(tkv_pkg::OP_DELETE, '0, '0, '0, '0, '0);
        add_op(tkv_pkg::OP_PUT,    '0, ones, 64'd7, 64'd9, 8'd3);
        add_op(tkv_pkg::OP_LOOKUP, '0, ones, '0, '0, '0);
        add_op(tkv_pkg::OP_PUT,    ones, '0, 64'd1, 64'd2, 8'd1);
        add_op(tkv_pkg::OP_LOOKUP, ones, '0, '0, '0, '0);
        add_op(tkv_pkg::OP_NOOP,   '0, '0, '0, '0, '0);

        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (((i / 100) % 2) == 1)
            begin
                key_range = 23;
                bucket_range = 1;
            end
            else
            begin
                key_range = KEY_POOL - 1;
                bucket_range = 2;
            end
            pick = $urandom_range(99);
            if (pick < 8)
                op = tkv_pkg::OP_NOOP;
            else if (pick < 55)
                op = tkv_pkg::OP_PUT;
            else if (pick < 75)
                op = tkv_pkg::OP_DELETE;
            else
                op = tkv_pkg::OP_LOOKUP;
            if ($urandom_range(99) < 5)
            begin
                b = rand64();
                k = rand64();
            end
            else
            begin
                b = bucket_pool[$urandom_range(bucket_range)];
                k = key_pool[$urandom_range(key_range)];
            end
            add_op(op, b, k, rand64(), rand64(), 8'($urandom));
        end
        total_ops = pending_ops.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (in_count < total_ops || expected_results.size() != 0)
            @(posedge clk);
        repeat (2 * tkv_pkg::ENTRIES + 8) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin : drive_blk
        table_result_t r;
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            operation      <= '0;
            bucket_tag     <= '0;
            key_tag        <= '0;
            object_size    <= '0;
            content_digest <= '0;
            chunk_count    <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_table_op(pending_ops[0], r);
                expected_results.push_back(r);
                void'(pending_ops.pop_front());
                in_count <= in_count + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_ops.size() > 0 && $urandom_range(99) >= sender_idle_pct(in_count))
                begin
                    in_valid       <= 1'b1;
                    operation      <= pending_ops[0].op;
                    bucket_tag     <= pending_ops[0].bucket;
                    key_tag        <= pending_ops[0].key;
                    object_size    <= pending_ops[0].size;
                    content_digest <= pending_ops[0].digest;
                    chunk_count    <= pending_ops[0].chunks;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor_blk
        table_result_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with no expectation: status %0d", status);
                    error_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (status !== e.st)
                    begin
                        $error("status: expected %0d, actual %0d", e.st, status);
                        error_count++;
                    end
                    if (found_size !== e.size)
                    begin
                        $error("found_size: expected %h, actual %h", e.size, found_size);
                        error_count++;
                    end
                    if (found_digest !== e.digest)
                    begin
                        $error("found_digest: expected %h, actual %h", e.digest, found_digest);
                        error_count++;
                    end
                    if (found_chunks !== e.chunks)
                    begin
                        $error("found_chunks: expected %h, actual %h", e.chunks, found_chunks);
                        error_count++;
                    end
                end
            end
            // hold off the output once so the table backs up into its input
            if (!hold_done && in_count >= HOLD_AT)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < receiver_idle_pct(in_count));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule

>>> filelist.f
hdl/tkv_pkg.sv
hdl/tkv_ram.sv
hdl/tombstone_key_value_table.sv
sim/tb_top.sv
